@@ hw/rtl/hkc_pkg.sv @@
// Shared types, codes and hash helpers for the hashed key cache.
`default_nettype none
package hkc_pkg;

	localparam int LEN_W = 9;

	localparam logic [63:0] HASH_BASIS = 64'd14695981039346656037;

	typedef enum logic [2:0] {
		STS_HIT    = 3'd0,
		STS_EMPTY  = 3'd1,
		STS_EVICT  = 3'd2,
		STS_REJECT = 3'd3,
		STS_NOMAKE = 3'd4
	} status_t;

	typedef struct packed {
		logic             valid;
		logic [LEN_W-1:0] len;
		logic [63:0]      stamp;
		logic [15:0]      pay;
	} meta_t;

	// Allowed hostname characters: letters, digits, dot, dash, underscore.
	function automatic logic char_ok(input logic [7:0] c);
		char_ok = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39) || c == 8'h2E || c == 8'h2D || c == 8'h5F;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	// FNV-1a step; prime is 2^40 + 2^8 + 0xB3, so shifts plus a narrow product.
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		fnv_step = (x << 40) + (x << 8) + (x * 64'd179);
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hashed_key_cache_lru_probe.sv @@
// Hostname key cache: byte intake, FNV-1a hash, linear probe with LRU eviction.
//
// Usage: one key byte is a request, taken at a clock edge with start high and
// busy low. Bytes of a key stream in at one per cycle; last_byte marks the
// final one, and new_handle / insert_allowed are sampled with it.
// Only a final byte yields a result: done pulses for one cycle with status,
// handle, slot, victim_handle and occupied_count. The receiver cannot stall;
// results must be taken in the cycle shown.
// Handling of a final byte: a rejected key (bad character, too long, or
// lookups disabled) reports in the cycle after it is taken. Otherwise the
// MOD steps reduce the hash mod TABLE_SLOTS by reciprocal multiplication
// (upper word, lower word, then the folded sum), then each probed slot has
// its metadata read (MRD, MCHK), and when the lengths agree its key is
// compared byte by byte (KA, KB, KC per byte; one key memory port serves
// both pending and stored bytes). The finish state then raises done. An
// insert copies the key after the result, CPA and CPB per key byte. busy
// is high throughout. Non-final bytes are taken back to back.
// Configuration: cfg_we writes cfg_wdata into lookups_enabled (reset 0); the
// user must write it only while the block is idle; the block does not enforce it.
// Reset: arst_n clears control state and starts a clearing pass that writes
// every slot of the metadata memory in turn, during which busy is high.
`default_nettype none
module hashed_key_cache_lru_probe
	import hkc_pkg::*;
#(
	parameter int TABLE_SLOTS   = 64,
	parameter int KEY_MAX_BYTES = 256,
	parameter int PROBE_LIMIT   = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [7:0]  key_byte,
	input  wire logic        last_byte,
	input  wire logic [15:0] new_handle,
	input  wire logic        insert_allowed,
	output logic             done,
	output logic [2:0]       status,
	output logic [15:0]      handle,
	output logic [5:0]       slot,
	output logic [15:0]      victim_handle,
	output logic [6:0]       occupied_count
);

	localparam int IW = $clog2(TABLE_SLOTS);
	localparam int KW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
	localparam int PW = $clog2(PROBE_LIMIT + 1);
	localparam int KDEPTH = (TABLE_SLOTS + 1) * KEY_MAX_BYTES;
	localparam int AW = $clog2(KDEPTH);
	// The pending key lives in the extra row after the table rows.
	localparam logic [IW:0] PEND_ROW = (IW+1)'(TABLE_SLOTS);
	// Exact 32-bit quotient: floor(x * RECIP / 2^(32+IW)) == floor(x / TABLE_SLOTS).
	localparam logic [63:0] RECIP = ((64'd1 << (32 + IW)) + 64'(TABLE_SLOTS - 1)) /
		64'(TABLE_SLOTS);
	// 2^32 mod TABLE_SLOTS, folds the upper word remainder into the lower one.
	localparam logic [31:0] WRAP32 = 32'((64'd1 << 32) % 64'(TABLE_SLOTS));

	typedef enum logic [10:0] {
		ST_CLR  = 11'b00000000001,
		ST_IDLE = 11'b00000000010,
		ST_MOD  = 11'b00000000100,
		ST_MRD  = 11'b00000001000,
		ST_MCHK = 11'b00000010000,
		ST_KA   = 11'b00000100000,
		ST_KB   = 11'b00001000000,
		ST_KC   = 11'b00010000000,
		ST_FIN  = 11'b00100000000,
		ST_CPA  = 11'b01000000000,
		ST_CPB  = 11'b10000000000
	} state_t;

	function automatic logic [AW-1:0] kaddr(input logic [IW:0] row,
		input logic [LEN_W-1:0] j);
		kaddr = AW'(row) * AW'(KEY_MAX_BYTES) + AW'(j[KW-1:0]);
	endfunction

	// memories
	logic [7:0]    key_mem [KDEPTH];
	meta_t         meta_mem [TABLE_SLOTS];
	logic          km_we;
	logic [AW-1:0] km_waddr, km_raddr;
	logic [7:0]    km_wdata, km_rdata;
	logic          mm_we;
	logic [IW-1:0] mm_waddr;
	meta_t         mm_wdata, mm_rdata;

	// control and datapath registers
	state_t           state_q;
	logic             en_q;
	logic [LEN_W-1:0] plen_q;
	logic             bad_q;
	logic [63:0]      hash_q;
	logic [2:0]       bitc_q;
	logic [31:0]      red_x_q;
	logic [31:0]      quo_q;
	logic [IW-1:0]    rhi_q;
	logic [IW-1:0]    idx_q;
	logic [PW-1:0]    step_q;
	logic [LEN_W-1:0] j_q;
	logic [7:0]       pb_q;
	meta_t            md_q;
	logic             have_lru_q, have_empty_q, hit_q;
	logic [63:0]      lru_stamp_q;
	logic [IW-1:0]    lru_idx_q;
	logic [15:0]      lru_pay_q;
	logic [15:0]      hdl_q;
	logic             ins_ok_q;
	logic [63:0]      use_q;
	logic [6:0]       cnt_q;

	logic             done_q;
	logic [2:0]       status_q;
	logic [15:0]      handle_q, victim_q;
	logic [5:0]       slot_q;
	logic [6:0]       occ_q;

	// intake
	logic             accept;
	logic [7:0]       lc;
	logic             room;
	logic             bad_n;
	logic [LEN_W-1:0] plen_n;
	logic [63:0]      hash_n;
	// remainder unit
	logic [64:0]      red_p;
	logic [31:0]      red_r;
	// probe walk
	logic [IW-1:0]    idx_inc;
	logic             win_end;
	logic             lru_take;
	logic [IW-1:0]    dst;
	logic [6:0]       cnt_n;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign lc     = to_lower(key_byte);
	assign room   = (plen_q < LEN_W'(KEY_MAX_BYTES));
	assign bad_n  = bad_q || !char_ok(key_byte) || !room;
	assign plen_n = room ? plen_q + 1'b1 : plen_q;
	assign hash_n = fnv_step(hash_q, lc);

	// quotient product is registered first, the remainder follows from it in the next cycle
	assign red_p = red_x_q * RECIP[32:0];
	assign red_r = red_x_q - quo_q * 32'(TABLE_SLOTS);

	assign idx_inc  = (idx_q == IW'(TABLE_SLOTS - 1)) ? '0 : idx_q + 1'b1;
	assign win_end  = (step_q == PW'(PROBE_LIMIT - 1));
	assign lru_take = !have_lru_q || (mm_rdata.stamp < lru_stamp_q);
	assign dst      = have_empty_q ? idx_q : lru_idx_q;
	assign cnt_n    = (have_empty_q && cnt_q != 7'd127) ? cnt_q + 1'b1 : cnt_q;

	// memory port control
	always_comb begin
		km_we    = 1'b0;
		km_waddr = kaddr(PEND_ROW, plen_q);
		km_wdata = lc;
		km_raddr = kaddr(PEND_ROW, j_q);
		mm_we    = 1'b0;
		mm_waddr = idx_q;
		mm_wdata = '0;
		unique case (state_q)
			ST_CLR: begin
				mm_we = 1'b1;
			end
			ST_IDLE: begin
				km_we = accept && room;
			end
			ST_KB: begin
				km_raddr = kaddr({1'b0, idx_q}, j_q);
			end
			ST_FIN: begin
				if (hit_q) begin
					mm_we    = 1'b1;
					mm_wdata = '{valid: 1'b1, len: md_q.len, stamp: use_q + 1'b1,
						pay: md_q.pay};
				end else if (ins_ok_q) begin
					mm_we    = 1'b1;
					mm_waddr = dst;
					mm_wdata = '{valid: 1'b1, len: plen_q, stamp: use_q + 1'b1,
						pay: hdl_q};
				end
			end
			ST_CPB: begin
				km_we    = 1'b1;
				km_waddr = kaddr({1'b0, idx_q}, j_q);
				km_wdata = km_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (km_we) begin
			key_mem[km_waddr] <= km_wdata;
		end
		km_rdata <= key_mem[km_raddr];
	end

	always_ff @(posedge clk) begin
		if (mm_we) begin
			meta_mem[mm_waddr] <= mm_wdata;
		end
		mm_rdata <= meta_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			en_q    <= 1'b0;
			plen_q  <= '0;
			bad_q   <= 1'b0;
			hash_q  <= HASH_BASIS;
			idx_q   <= '0;
			use_q   <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				en_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_CLR: begin
					if (idx_q == IW'(TABLE_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (!last_byte) begin
							plen_q <= plen_n;
							bad_q  <= bad_n;
							hash_q <= hash_n;
						end else if (bad_n || !en_q) begin
							done_q   <= 1'b1;
							status_q <= STS_REJECT;
							handle_q <= '0;
							slot_q   <= '0;
							victim_q <= '0;
							occ_q    <= cnt_q;
							plen_q   <= '0;
							bad_q    <= 1'b0;
							hash_q   <= HASH_BASIS;
						end else begin
							plen_q   <= plen_n;
							hash_q   <= hash_n;
							hdl_q    <= new_handle;
							ins_ok_q <= insert_allowed;
							red_x_q  <= hash_n[63:32];
							bitc_q   <= '0;
							state_q  <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					bitc_q <= bitc_q + 1'b1;
					unique case (bitc_q)
						3'd0, 3'd2, 3'd5: begin
							quo_q <= 32'(red_p >> (32 + IW));
						end
						3'd1: begin
							rhi_q   <= red_r[IW-1:0];
							red_x_q <= hash_q[31:0];
						end
						3'd3: begin
							idx_q <= red_r[IW-1:0];
						end
						3'd4: begin
							red_x_q <= {{(32-IW){1'b0}}, rhi_q} * WRAP32 +
								{{(32-IW){1'b0}}, idx_q};
						end
						default: begin
							idx_q        <= red_r[IW-1:0];
							step_q       <= '0;
							have_lru_q   <= 1'b0;
							have_empty_q <= 1'b0;
							hit_q        <= 1'b0;
							hash_q       <= HASH_BASIS;
							state_q      <= ST_MRD;
						end
					endcase
				end
				ST_MRD: begin
					state_q <= ST_MCHK;
				end
				ST_MCHK: begin
					md_q <= mm_rdata;
					if (!mm_rdata.valid) begin
						have_empty_q <= 1'b1;
						state_q      <= ST_FIN;
					end else begin
						if (lru_take) begin
							have_lru_q  <= 1'b1;
							lru_stamp_q <= mm_rdata.stamp;
							lru_idx_q   <= idx_q;
							lru_pay_q   <= mm_rdata.pay;
						end
						if (mm_rdata.len == plen_q) begin
							j_q     <= '0;
							state_q <= ST_KA;
						end else if (win_end) begin
							state_q <= ST_FIN;
						end else begin
							step_q  <= step_q + 1'b1;
							idx_q   <= idx_inc;
							state_q <= ST_MRD;
						end
					end
				end
				ST_KA: begin
					state_q <= ST_KB;
				end
				ST_KB: begin
					pb_q    <= km_rdata;
					state_q <= ST_KC;
				end
				ST_KC: begin
					if (km_rdata != pb_q) begin
						if (win_end) begin
							state_q <= ST_FIN;
						end else begin
							step_q  <= step_q + 1'b1;
							idx_q   <= idx_inc;
							state_q <= ST_MRD;
						end
					end else if (j_q == plen_q - 1'b1) begin
						hit_q   <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_KA;
					end
				end
				ST_FIN: begin
					done_q   <= 1'b1;
					victim_q <= '0;
					if (hit_q) begin
						use_q    <= use_q + 1'b1;
						status_q <= STS_HIT;
						handle_q <= md_q.pay;
						slot_q   <= 6'(idx_q);
						occ_q    <= cnt_q;
						plen_q   <= '0;
						state_q  <= ST_IDLE;
					end else if (!ins_ok_q) begin
						status_q <= STS_NOMAKE;
						handle_q <= '0;
						slot_q   <= '0;
						occ_q    <= cnt_q;
						plen_q   <= '0;
						state_q  <= ST_IDLE;
					end else begin
						use_q    <= use_q + 1'b1;
						cnt_q    <= cnt_n;
						status_q <= have_empty_q ? STS_EMPTY : STS_EVICT;
						handle_q <= hdl_q;
						slot_q   <= 6'(dst);
						victim_q <= have_empty_q ? 16'd0 : lru_pay_q;
						occ_q    <= cnt_n;
						idx_q    <= dst;
						j_q      <= '0;
						state_q  <= ST_CPA;
					end
				end
				ST_CPA: begin
					state_q <= ST_CPB;
				end
				ST_CPB: begin
					if (j_q == plen_q - 1'b1) begin
						plen_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_CPA;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign handle         = handle_q;
	assign slot           = slot_q;
	assign victim_handle  = victim_q;
	assign occupied_count = occ_q;

	// occupancy never drops
	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= $past(cnt_q))
		else $error("entry count decreased");

	// a victim is reported only on eviction
	a_victim: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != STS_EVICT |-> victim_handle == 16'd0)
		else $error("victim handle without eviction");

	// results come only from a rejected final byte or the finish step
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_FIN || (state_q == ST_IDLE && start)))
		else $error("unexpected result strobe");

	// a probe never runs past its window
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MCHK |-> step_q < PW'(PROBE_LIMIT))
		else $error("probe past window");

endmodule
`default_nettype wire
